[hw/rtl/fqs_pkg.sv]
// fqs_pkg: shared types and constants of the FIFO queue with search.
// Depends on nothing; used by the controller, datapath and top level.
package fqs_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int ACT_BITS      = 2;
  localparam int STATUS_BITS   = 2;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_SEARCH  = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic front_cap;
    logic scan;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    empty;
    logic    multi;
    logic    scan_done;
  } dp_stat_t;

endpackage

[hw/rtl/fqs_if.sv]
// fqs_req_if and fqs_rsp_if: valid/ready channels of the FIFO queue.
// Depends on nothing; widths are set by the instantiating level.
interface fqs_req_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic signed [WORD_BITS-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface fqs_rsp_if #(
  parameter int WORD_BITS = 32,
  parameter int CNT_BITS  = 5
);
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic signed [WORD_BITS-1:0] removed_word;
  logic                        found;
  logic signed [WORD_BITS-1:0] front_word;
  logic signed [WORD_BITS-1:0] rear_word;
  logic                        is_empty;
  logic [CNT_BITS-1:0]         entry_count;

  modport source (output valid, output status, output removed_word, output found,
                  output front_word, output rear_word, output is_empty,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input removed_word, input found,
                  input front_word, input rear_word, input is_empty,
                  input entry_count, output ready);
endinterface

[hw/rtl/fqs_ram.sv]
// fqs_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fqs_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/fqs_ctrl.sv]
// fqs_ctrl: sequencing state machine of the FIFO queue with search.
// Depends on fqs_pkg; drives the datapath commands and channel handshakes.
module fqs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output fqs_pkg::dp_cmd_t  cmd,
  input  fqs_pkg::dp_stat_t stat
);
  import fqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FRONT,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.latch     = (state == S_IDLE) && req_valid;
    cmd.exec      = (state == S_EXEC);
    cmd.front_cap = (state == S_FRONT);
    cmd.scan      = (state == S_SCAN);
    cmd.load_out  = (state == S_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_FINISH && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (stat.action == ACT_DEQUEUE && stat.multi) begin
            state <= S_FRONT;
          end else if (stat.action == ACT_SEARCH && !stat.empty) begin
            state <= S_SCAN;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FRONT: begin
          state <= S_FINISH;
        end
        S_SCAN: begin
          if (stat.scan_done) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_EXEC))
    else $error("accepted beat did not move to execute");

  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (rsp_valid && state == S_IDLE))
    else $error("finished result not presented");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.scan_done) |=> (state == S_FINISH))
    else $error("search did not end when done");

endmodule

[hw/rtl/fqs_dp.sv]
// fqs_dp: queue pointers, front/rear words, search scan and result register.
// Depends on fqs_pkg; drives the entry store RAM ports.
module fqs_dp #(
  parameter int  DEPTH     = fqs_pkg::DEPTH_DEF,
  parameter int  WORD_BITS = fqs_pkg::WORD_BITS_DEF,
  localparam int IDX_BITS  = $clog2(DEPTH),
  localparam int CNT_BITS  = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fqs_pkg::dp_cmd_t            cmd,
  output fqs_pkg::dp_stat_t           stat,
  input  logic [1:0]                  req_action,
  input  logic signed [WORD_BITS-1:0] req_value,
  output logic [1:0]                  rsp_status,
  output logic signed [WORD_BITS-1:0] rsp_removed_word,
  output logic                        rsp_found,
  output logic signed [WORD_BITS-1:0] rsp_front_word,
  output logic signed [WORD_BITS-1:0] rsp_rear_word,
  output logic                        rsp_is_empty,
  output logic [CNT_BITS-1:0]         rsp_entry_count,
  output logic                        ram_we,
  output logic [IDX_BITS-1:0]         ram_waddr,
  output logic [WORD_BITS-1:0]        ram_wdata,
  output logic                        ram_re,
  output logic [IDX_BITS-1:0]         ram_raddr,
  input  logic [WORD_BITS-1:0]        ram_rdata
);
  import fqs_pkg::*;

  function automatic logic [IDX_BITS-1:0] step_idx(input logic [IDX_BITS-1:0] i);
    return (i == IDX_BITS'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  logic [IDX_BITS-1:0]         head;
  logic [IDX_BITS-1:0]         tail;
  logic [CNT_BITS-1:0]         count;
  logic [IDX_BITS-1:0]         scan_slot;
  logic [CNT_BITS-1:0]         scan_left;
  logic                        cmp_valid;
  action_t                     act_q;
  logic signed [WORD_BITS-1:0] val_q;
  logic signed [WORD_BITS-1:0] front_q;
  logic signed [WORD_BITS-1:0] rear_q;
  status_t                     res_status;
  logic signed [WORD_BITS-1:0] res_removed;
  logic                        res_found;
  logic [IDX_BITS-1:0]         head_nx;
  logic                        empty;
  logic                        full;
  logic                        hit;

  assign head_nx = step_idx(head);
  assign empty   = (count == '0);
  assign full    = (count == CNT_BITS'(DEPTH));
  assign hit     = (ram_rdata == val_q);

  always_comb begin
    stat           = '0;
    stat.action    = act_q;
    stat.empty     = empty;
    stat.multi     = (count > CNT_BITS'(1));
    stat.scan_done = cmp_valid && (hit || scan_left == '0);
  end

  assign ram_we    = cmd.exec && act_q == ACT_ENQUEUE && !full;
  assign ram_waddr = tail;
  assign ram_wdata = val_q;
  assign ram_re    = (cmd.exec && act_q == ACT_DEQUEUE) || (cmd.scan && scan_left != '0);
  assign ram_raddr = cmd.scan ? scan_slot : head_nx;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      scan_slot <= '0;
      scan_left <= '0;
      cmp_valid <= 1'b0;
    end else begin
      if (cmd.exec) begin
        unique case (act_q)
          ACT_ENQUEUE: begin
            if (!full) begin
              tail  <= step_idx(tail);
              count <= count + 1'b1;
            end
          end
          ACT_DEQUEUE: begin
            if (!empty) begin
              head  <= head_nx;
              count <= count - 1'b1;
            end
          end
          ACT_SEARCH: begin
            scan_slot <= head;
            scan_left <= count;
            cmp_valid <= 1'b0;
          end
          ACT_CLEAR: begin
            head  <= '0;
            tail  <= '0;
            count <= '0;
          end
        endcase
      end
      if (cmd.scan) begin
        if (scan_left != '0) begin
          scan_slot <= step_idx(scan_slot);
          scan_left <= scan_left - 1'b1;
        end
        cmp_valid <= (scan_left != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q       <= action_t'(req_action);
      val_q       <= req_value;
      res_status  <= ST_DONE;
      res_removed <= '0;
      res_found   <= 1'b0;
    end
    if (cmd.exec) begin
      unique case (act_q)
        ACT_ENQUEUE: begin
          if (full) begin
            res_status <= ST_FULL;
          end else begin
            rear_q <= val_q;
            if (empty) begin
              front_q <= val_q;
            end
          end
        end
        ACT_DEQUEUE: begin
          if (empty) begin
            res_status <= ST_EMPTY;
          end else begin
            res_removed <= front_q;
          end
        end
        ACT_SEARCH, ACT_CLEAR: begin
          if (empty) begin
            res_status <= ST_EMPTY;
          end
        end
      endcase
    end
    if (cmd.front_cap) begin
      front_q <= ram_rdata;
    end
    if (cmd.scan && cmp_valid) begin
      res_found <= hit;
    end
    if (cmd.load_out) begin
      rsp_status       <= res_status;
      rsp_removed_word <= res_removed;
      rsp_found        <= res_found;
      rsp_front_word   <= empty ? '0 : front_q;
      rsp_rear_word    <= empty ? '0 : rear_q;
      rsp_is_empty     <= empty;
      rsp_entry_count  <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("entry count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    empty |-> (head == tail))
    else $error("empty queue with unequal pointers");

  a_full_ptrs: assert property (@(posedge clk) disable iff (rst)
    full |-> (head == tail))
    else $error("full queue with unequal pointers");

endmodule

[hw/rtl/fifo_queue_with_search_unit.sv]
// fifo_queue_with_search_unit: top level of the FIFO queue with search.
// Depends on fqs_pkg, fqs_if, fqs_ram, fqs_ctrl and fqs_dp.
//
//   channel  dir  payload
//   req      in   action, value
//   rsp      out  status, removed_word, found, front_word, rear_word,
//                 is_empty, entry_count
//
// Enqueue, clear and empty-queue items pass through execute and finish only;
// dequeue leaving entries adds a front state for one RAM read of the new front.
// Search over held entries adds a scan state that ends early when a match is
// found, with the single RAM read port scanning one entry per cycle.
// Synchronous reset empties the queue without touching the store.
// A stalled result holds in the output register while the next beat is
// accepted; that beat waits before loading its result.
module fifo_queue_with_search_unit #(
  parameter int  DEPTH     = fqs_pkg::DEPTH_DEF,
  parameter int  WORD_BITS = fqs_pkg::WORD_BITS_DEF,
  localparam int IDX_BITS  = $clog2(DEPTH)
) (
  input logic       clk,
  input logic       rst,
  fqs_req_if.sink   req,
  fqs_rsp_if.source rsp
);
  import fqs_pkg::*;

  dp_cmd_t               cmd;
  dp_stat_t              stat;
  logic                  ram_we;
  logic [IDX_BITS-1:0]   ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic                  ram_re;
  logic [IDX_BITS-1:0]   ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;

  fqs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  fqs_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .req_action       (req.action),
    .req_value        (req.value),
    .rsp_status       (rsp.status),
    .rsp_removed_word (rsp.removed_word),
    .rsp_found        (rsp.found),
    .rsp_front_word   (rsp.front_word),
    .rsp_rear_word    (rsp.rear_word),
    .rsp_is_empty     (rsp.is_empty),
    .rsp_entry_count  (rsp.entry_count),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_re           (ram_re),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata)
  );

  fqs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[tb/fifo_queue_with_search_unit_tb.sv]
// fifo_queue_with_search_unit_tb: self-checking bench for the FIFO queue with search.
// A scoreboard class tracks the queue state and checks each response beat.
// Depends on fqs_pkg, fqs_if and the fifo_queue_with_search_unit RTL.
import fqs_pkg::*;

localparam int Q_DEPTH = fqs_pkg::DEPTH_DEF;
localparam int WB      = fqs_pkg::WORD_BITS_DEF;
localparam int CB      = $clog2(Q_DEPTH + 1);

typedef struct packed {
  logic [1:0]           status;
  logic signed [WB-1:0] removed_word;
  logic                 found;
  logic signed [WB-1:0] front_word;
  logic signed [WB-1:0] rear_word;
  logic                 is_empty;
  logic [CB-1:0]        entry_count;
} queue_result_t;

typedef enum int {
  MIX_FILL,
  MIX_DRAIN,
  MIX_ANY
} mix_t;

class queue_scoreboard;
  logic signed [WB-1:0] slots [Q_DEPTH];
  int head;
  int tail;
  int held;
  int errors;
  queue_result_t awaited_results [$];

  function new();
    head   = 0;
    tail   = 0;
    held   = 0;
    errors = 0;
  endfunction

  function int next_slot(int s);
    return (s == Q_DEPTH - 1) ? 0 : s + 1;
  endfunction

  function logic signed [WB-1:0] held_word(int k);
    return slots[(head + k) % Q_DEPTH];
  endfunction

  function void apply_action(action_t act, logic signed [WB-1:0] word);
    queue_result_t r;
    int s;
    r = '0;
    r.status = ST_DONE;
    case (act)
      ACT_ENQUEUE: begin
        if (held >= Q_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[tail] = word;
          tail = next_slot(tail);
          held++;
        end
      end
      ACT_DEQUEUE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_word = slots[head];
          head = next_slot(head);
          held--;
        end
      end
      ACT_SEARCH: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          s = head;
          for (int k = 0; k < held; k++) begin
            if (slots[s] == word) r.found = 1'b1;
            s = next_slot(s);
          end
        end
      end
      default: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          head = 0;
          tail = 0;
          held = 0;
        end
      end
    endcase
    if (held != 0) begin
      r.front_word = slots[head];
      r.rear_word  = slots[(tail == 0) ? Q_DEPTH - 1 : tail - 1];
    end
    r.is_empty    = (held == 0);
    r.entry_count = CB'(held);
    awaited_results.push_back(r);
  endfunction

  function void compare(string field, logic [WB-1:0] want, logic [WB-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_response(queue_result_t got);
    queue_result_t want;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected response, expected none, actual status %0d count %0d",
               $time, got.status, got.entry_count);
      errors++;
      return;
    end
    want = awaited_results.pop_front();
    compare("status", want.status, got.status);
    compare("removed_word", want.removed_word, got.removed_word);
    compare("found", want.found, got.found);
    compare("front_word", want.front_word, got.front_word);
    compare("rear_word", want.rear_word, got.rear_word);
    compare("is_empty", want.is_empty, got.is_empty);
    compare("entry_count", want.entry_count, got.entry_count);
  endfunction
endclass

module fifo_queue_with_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int STALL_CYCLES = 300;

  logic clk;
  logic rst;
  logic stall_request;
  bit   stall_done;
  int   stall_left;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   cycle_count;
  queue_scoreboard sb;
  queue_result_t seen_rsp;

  fqs_req_if #(.WORD_BITS(WB)) req_ch ();
  fqs_rsp_if #(.WORD_BITS(WB), .CNT_BITS(CB)) rsp_ch ();

  fifo_queue_with_search_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fifo_queue_with_search_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request && !stall_done) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen_rsp.status       = rsp_ch.status;
      seen_rsp.removed_word = rsp_ch.removed_word;
      seen_rsp.found        = rsp_ch.found;
      seen_rsp.front_word   = rsp_ch.front_word;
      seen_rsp.rear_word    = rsp_ch.rear_word;
      seen_rsp.is_empty     = rsp_ch.is_empty;
      seen_rsp.entry_count  = rsp_ch.entry_count;
      sb.check_response(seen_rsp);
    end
  end

  task automatic send_beat(action_t act, logic signed [WB-1:0] value);
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.value  <= value;
    do @(posedge clk); while (!req_ch.ready);
    sb.apply_action(act, value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic logic signed [WB-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4: begin
        case ($urandom_range(3))
          0: return {1'b1, {(WB-1){1'b0}}};
          1: return {1'b0, {(WB-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(15);
    endcase
  endfunction

  task automatic run_random(int n_items, int s_idle, int r_idle);
    int left;
    int burst;
    int roll;
    mix_t mode;
    action_t act;
    logic signed [WB-1:0] value;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    left = n_items;
    mode = MIX_FILL;
    while (left > 0) begin
      burst = $urandom_range(28, 8);
      while (burst > 0 && left > 0) begin
        roll = $urandom_range(99);
        case (mode)
          MIX_FILL:
            act = (roll < 72) ? ACT_ENQUEUE : (roll < 88) ? ACT_SEARCH :
                  (roll < 99) ? ACT_DEQUEUE : ACT_CLEAR;
          MIX_DRAIN:
            act = (roll < 65) ? ACT_DEQUEUE : (roll < 85) ? ACT_SEARCH :
                  (roll < 97) ? ACT_ENQUEUE : ACT_CLEAR;
          default:
            act = (roll < 35) ? ACT_ENQUEUE : (roll < 65) ? ACT_DEQUEUE :
                  (roll < 93) ? ACT_SEARCH : ACT_CLEAR;
        endcase
        value = pick_value();
        if (act == ACT_SEARCH && sb.held > 0 && $urandom_range(9) < 6)
          value = sb.held_word($urandom_range(sb.held - 1));
        send_beat(act, value);
        burst--;
        left--;
      end
      mode = mix_t'($urandom_range(2));
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 20;
    recv_idle_pct = 81;
    rst           <= 1'b1;
    stall_request <= 1'b0;
    req_ch.valid  <= 1'b0;
    req_ch.action <= ACT_ENQUEUE;
    req_ch.value  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_beat(ACT_DEQUEUE, '0);
    send_beat(ACT_SEARCH, '0);
    send_beat(ACT_CLEAR, '0);
    send_beat(ACT_ENQUEUE, {1'b1, {(WB-1){1'b0}}});
    send_beat(ACT_ENQUEUE, {1'b0, {(WB-1){1'b1}}});
    send_beat(ACT_SEARCH, {1'b0, {(WB-1){1'b1}}});
    send_beat(ACT_SEARCH, {1'b1, {(WB-1){1'b0}}});
    send_beat(ACT_SEARCH, '0);
    send_beat(ACT_DEQUEUE, '0);
    send_beat(ACT_SEARCH, {1'b1, {(WB-1){1'b0}}});
    send_beat(ACT_DEQUEUE, '0);
    send_beat(ACT_ENQUEUE, '1);
    send_beat(ACT_ENQUEUE, '0);
    send_beat(ACT_ENQUEUE, '1);
    send_beat(ACT_SEARCH, '1);
    send_beat(ACT_CLEAR, '1);
    send_beat(ACT_DEQUEUE, '1);

    run_random(245, 20, 81);
    run_random(245, 81, 20);
    stall_request <= 1'b1;
    run_random(245, 0, 0);

    req_ch.valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("fifo_queue_with_search_unit_tb OK");
    end else begin
      $display("fifo_queue_with_search_unit_tb NOT OK");
    end
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/fqs_pkg.sv
hw/rtl/fqs_if.sv
hw/rtl/fqs_ram.sv
hw/rtl/fqs_ctrl.sv
hw/rtl/fqs_dp.sv
hw/rtl/fifo_queue_with_search_unit.sv
tb/fifo_queue_with_search_unit_tb.sv
